// ===== rtl/plsu_pkg.sv =====
// shared types and constants for the positional list store
package plsu_pkg;

	localparam int IDX_W = 7;
	localparam int DATA_W = 32;

	localparam logic [2:0] FUNC_INS_FIRST = 3'd0;
	localparam logic [2:0] FUNC_INS_LAST  = 3'd1;
	localparam logic [2:0] FUNC_INS_POS   = 3'd2;
	localparam logic [2:0] FUNC_DEL_FIRST = 3'd3;
	localparam logic [2:0] FUNC_DEL_LAST  = 3'd4;
	localparam logic [2:0] FUNC_DEL_POS   = 3'd5;
	localparam logic [2:0] FUNC_DUMP      = 3'd6;

	localparam logic [1:0] ST_DONE    = 2'd0;
	localparam logic [1:0] ST_INVALID = 2'd1;
	localparam logic [1:0] ST_FULL    = 2'd2;
	localparam logic [1:0] ST_EMPTY   = 2'd3;

	typedef struct packed {
		logic [2:0]               func;
		logic signed [DATA_W-1:0] value;
		logic [5:0]               position;
	} list_cmd_t;

	typedef struct packed {
		logic [1:0]               status;
		logic [5:0]               element_count;
		logic signed [DATA_W-1:0] element_value;
		logic                     last_result;
	} list_rsp_t;

	typedef enum logic [1:0] {
		CHAIN_IDLE,
		CHAIN_INSERT,
		CHAIN_DELETE,
		CHAIN_ROTATE
	} chain_mode_t;

	typedef struct packed {
		chain_mode_t       mode;
		logic [IDX_W-1:0]  idx;
		logic [DATA_W-1:0] value;
	} cell_ctl_t;

	typedef enum logic {
		FSM_IDLE,
		FSM_DUMP
	} fsm_state_t;

endpackage

// ===== rtl/plsu_cell.sv =====
// one storage cell of the list chain
module plsu_cell #(
	parameter int INDEX = 0
) (
	input  logic                       clk,
	input  plsu_pkg::cell_ctl_t        ctl,
	input  logic [plsu_pkg::DATA_W-1:0] left_data,
	input  logic [plsu_pkg::DATA_W-1:0] right_data,
	input  logic [plsu_pkg::DATA_W-1:0] head_data,
	output logic [plsu_pkg::DATA_W-1:0] data
);
	import plsu_pkg::*;

	localparam logic [IDX_W-1:0] MY_IDX = IDX_W'(INDEX);

	logic [DATA_W-1:0] data_q;
	logic [DATA_W-1:0] data_d;

	always_comb begin
		data_d = data_q;
		case (ctl.mode)
			CHAIN_INSERT: begin
				if (MY_IDX == ctl.idx) begin
					data_d = ctl.value;
				end else if (MY_IDX > ctl.idx) begin
					data_d = left_data;
				end
			end
			CHAIN_DELETE: begin
				if (MY_IDX >= ctl.idx) begin
					data_d = right_data;
				end
			end
			CHAIN_ROTATE: begin
				if (MY_IDX == ctl.idx) begin
					data_d = head_data;
				end else if (MY_IDX < ctl.idx) begin
					data_d = right_data;
				end
			end
			default: begin
				data_d = data_q;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		data_q <= data_d;
	end

	assign data = data_q;

endmodule

// ===== rtl/positional_list_store_unit.sv =====
// top level of the positional list store: control and the cell chain
//
// channel   handshake          payload
// command   start / busy       cmd  (func, value, position)
// result    strobe             rsp  (status, element_count, element_value, last_result)
//
// insert, delete and invalid requests give their result in the next cycle, and a new
// item can be accepted in that same cycle
// a dump of a non-empty list raises busy after the accepting cycle, the chain rotating
// by one cell for each element; its results follow back to back and the last one shows
// in the cycle busy falls; a dump of an empty list gives one empty result and no busy
// arst_n clears the count, the state and the strobe; cell contents are not reset
// results cannot be stalled
module positional_list_store_unit #(
	parameter int CAPACITY = 32
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	output logic                busy,
	input  plsu_pkg::list_cmd_t cmd,
	output logic                strobe,
	output plsu_pkg::list_rsp_t rsp
);
	import plsu_pkg::*;

	localparam int CW = $clog2(CAPACITY + 1);
	localparam logic [IDX_W-1:0] CAP_I = IDX_W'(CAPACITY);

	fsm_state_t state_q, state_d;
	logic [CW-1:0] count_q, count_d;
	logic [CW-1:0] dump_q, dump_d;
	logic          strobe_q, strobe_d;
	list_rsp_t     rsp_q, rsp_d;
	cell_ctl_t     ctl;

	logic [DATA_W-1:0] cell_data [CAPACITY];

	logic [IDX_W-1:0] cnt_i;
	logic [IDX_W-1:0] pos_i;
	logic [IDX_W-1:0] dump_i;
	logic [CW+5:0]    count_ext;
	logic             full;
	logic             empty;

	assign cnt_i  = IDX_W'(count_q);
	assign pos_i  = IDX_W'(cmd.position);
	assign dump_i = IDX_W'(dump_q);
	assign full   = (cnt_i == CAP_I);
	assign empty  = (cnt_i == '0);

	always_comb begin
		state_d   = state_q;
		count_d   = count_q;
		dump_d    = dump_q;
		strobe_d  = 1'b0;
		rsp_d     = rsp_q;
		ctl.mode  = CHAIN_IDLE;
		ctl.idx   = '0;
		ctl.value = cmd.value;
		count_ext = '0;
		case (state_q)
			FSM_IDLE: begin
				if (start) begin
					rsp_d.status        = ST_DONE;
					rsp_d.element_value = '0;
					rsp_d.last_result   = 1'b1;
					strobe_d            = 1'b1;
					case (cmd.func)
						FUNC_INS_FIRST, FUNC_INS_LAST: begin
							if (full) begin
								rsp_d.status = ST_FULL;
							end else begin
								ctl.mode = CHAIN_INSERT;
								ctl.idx  = (cmd.func == FUNC_INS_FIRST) ? '0 : cnt_i;
								count_d  = count_q + 1'b1;
							end
						end
						FUNC_INS_POS: begin
							if (pos_i == '0 || pos_i > cnt_i + 1'b1) begin
								rsp_d.status = ST_INVALID;
							end else if (full) begin
								rsp_d.status = ST_FULL;
							end else begin
								ctl.mode = CHAIN_INSERT;
								ctl.idx  = pos_i - 1'b1;
								count_d  = count_q + 1'b1;
							end
						end
						FUNC_DEL_FIRST, FUNC_DEL_LAST: begin
							if (empty) begin
								rsp_d.status = ST_EMPTY;
							end else begin
								ctl.mode = CHAIN_DELETE;
								ctl.idx  = (cmd.func == FUNC_DEL_FIRST) ? '0 : cnt_i - 1'b1;
								count_d  = count_q - 1'b1;
							end
						end
						FUNC_DEL_POS: begin
							if (empty) begin
								rsp_d.status = ST_EMPTY;
							end else if (pos_i == '0 || pos_i > cnt_i) begin
								rsp_d.status = ST_INVALID;
							end else begin
								ctl.mode = CHAIN_DELETE;
								ctl.idx  = pos_i - 1'b1;
								count_d  = count_q - 1'b1;
							end
						end
						FUNC_DUMP: begin
							if (empty) begin
								rsp_d.status = ST_EMPTY;
							end else begin
								strobe_d = 1'b0;
								dump_d   = '0;
								state_d  = FSM_DUMP;
							end
						end
						default: begin
							rsp_d.status = ST_INVALID;
						end
					endcase
				end
			end
			FSM_DUMP: begin
				ctl.mode            = CHAIN_ROTATE;
				ctl.idx             = cnt_i - 1'b1;
				strobe_d            = 1'b1;
				rsp_d.status        = ST_DONE;
				rsp_d.element_value = cell_data[0];
				rsp_d.last_result   = (dump_i == cnt_i - 1'b1);
				dump_d              = dump_q + 1'b1;
				if (dump_i == cnt_i - 1'b1) begin
					state_d = FSM_IDLE;
				end
			end
			default: begin
				state_d = FSM_IDLE;
			end
		endcase
		count_ext           = {6'd0, count_d};
		rsp_d.element_count = count_ext[5:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= FSM_IDLE;
			count_q  <= '0;
			dump_q   <= '0;
			strobe_q <= 1'b0;
		end else begin
			state_q  <= state_d;
			count_q  <= count_d;
			dump_q   <= dump_d;
			strobe_q <= strobe_d;
		end
	end

	always_ff @(posedge clk) begin
		rsp_q <= rsp_d;
	end

	for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
		logic [DATA_W-1:0] left_w;
		logic [DATA_W-1:0] right_w;
		if (g == 0) begin : g_first
			assign left_w = '0;
		end else begin : g_mid_l
			assign left_w = cell_data[g-1];
		end
		if (g == CAPACITY - 1) begin : g_last
			assign right_w = '0;
		end else begin : g_mid_r
			assign right_w = cell_data[g+1];
		end
		plsu_cell #(
			.INDEX(g)
		) u_cell (
			.clk       (clk),
			.ctl       (ctl),
			.left_data (left_w),
			.right_data(right_w),
			.head_data (cell_data[0]),
			.data      (cell_data[g])
		);
	end

	assign busy   = (state_q == FSM_DUMP);
	assign strobe = strobe_q;
	assign rsp    = rsp_q;

endmodule

// ===== rtl/plsu_checker.sv =====
// port-level checks for the positional list store, bound to the top level
module plsu_checker (
	input logic                clk,
	input logic                arst_n,
	input logic                start,
	input logic                busy,
	input plsu_pkg::list_cmd_t cmd,
	input logic                strobe,
	input plsu_pkg::list_rsp_t rsp
);
	import plsu_pkg::*;

	// an accepted item gives a result next cycle or starts a dump
	a_accept_progress: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |=> strobe || busy)
		else $error("accepted item produced neither result nor dump");

	// dump results stream without gaps until the last one
	a_dump_continuous: assert property (@(posedge clk) disable iff (!arst_n)
		strobe && !rsp.last_result |=> strobe)
		else $error("gap inside a dump");

	// a non-final result only comes from a dump in progress
	a_dump_busy: assert property (@(posedge clk) disable iff (!arst_n)
		strobe && !rsp.last_result |-> busy && rsp.status == ST_DONE)
		else $error("partial result outside a dump");

	// failed requests carry no element and end the item
	a_fail_shape: assert property (@(posedge clk) disable iff (!arst_n)
		strobe && rsp.status != ST_DONE |-> rsp.last_result && rsp.element_value == '0)
		else $error("bad shape of failed result");

endmodule

bind positional_list_store_unit plsu_checker u_plsu_checker (.*);
